// ===== rtl/rgbhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_pkg: shared types and constants for the RGB to HSL converter
// Holds the word carried down the divider row and the fixed scale constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsl_pkg;

   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned QUO_W     = 8;
   localparam int unsigned NUM_CELLS = QUO_W;
   localparam int unsigned NUM_W     = 2 * QUO_W;

   // floor(x / 17) equals (x * 3856) >> 16 for every x up to 4080, so
   // floor(sum * 240 / 510) = floor(sum * 8 / 17) = (sum * 3856) >> 13.
   localparam logic [11:0] LIGHT_RECIP = 12'd3856;
   localparam int unsigned LIGHT_SHIFT = 13;

   // One restoring divider lane. The partial remainder always stays below
   // the divisor, and the low numerator bits are shifted in one per cell.
   typedef struct packed {
      logic [QUO_W-1:0]  rem;
      logic [QUO_W-1:0]  num_lo;
      logic [QUO_W-1:0]  quo;
      logic [CHAN_W-1:0] divisor;
   } div_lane_type;

   typedef struct packed {
      div_lane_type      hue;
      div_lane_type      sat;
      logic [CHAN_W-1:0] lightness;
   } pixel_work_type;

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsl_240.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_240: RGB to HSL colour converter on a 0 to 240 scale
// Converts one 8-bit RGB pixel to HSL per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request word passes one setup stage and then eight
//   divider cells on its way to the response word, one quotient bit per cell.
// Throughput: one pixel per clock when the response side does not stall.
// Reset: synchronous, active high; it empties every stage of the row, so no
//   response word is shown after reset. Payload registers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_240 (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_hue,
   output logic [7:0]      rsp_saturation,
   output logic [7:0]      rsp_lightness
);

   // Stage 0 is the setup stage; stages 1 to NUM_CELLS are divider cells.
   // Each stage holds a word and moves it on when the next stage can take it,
   // so bubbles close up and a new word enters while a response waits, as
   // long as any stage of the row is free.
   logic                       stage_valid [rgbhsl_pkg::NUM_CELLS+1];
   rgbhsl_pkg::pixel_work_type stage_data  [rgbhsl_pkg::NUM_CELLS+1];
   logic                       stage_en    [rgbhsl_pkg::NUM_CELLS+2];

   // The last enable comes from the response side: the final cell is the
   // output register and may be refilled whenever its word is taken.
   assign stage_en[rgbhsl_pkg::NUM_CELLS+1] = !rsp_stall;

   // The setup stage finds the largest and smallest channel, computes the
   // lightness by a reciprocal multiply and loads the hue and saturation
   // numerators and divisors. A grey pixel gets a divisor of one, so both
   // zero numerators give a zero quotient.
   rgbhsl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .down_en  (stage_en[1]),
      .valid    (stage_valid[0]),
      .data     (stage_data[0]),
      .en       (stage_en[0])
   );

   // The divider row: every cell performs one restoring step on each lane,
   // from the most significant quotient bit down to the least.
   for (genvar i = 1; i <= rgbhsl_pkg::NUM_CELLS; i++) begin : g_cell
      rgbhsl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[i-1]),
         .up_data  (stage_data[i-1]),
         .down_en  (stage_en[i+1]),
         .valid    (stage_valid[i]),
         .data     (stage_data[i]),
         .en       (stage_en[i])
      );
   end

   assign req_stall = !stage_en[0];

   // The quotients after the last cell are the hue and saturation.
   assign rsp_valid      = stage_valid[rgbhsl_pkg::NUM_CELLS];
   assign rsp_hue        = stage_data[rgbhsl_pkg::NUM_CELLS].hue.quo;
   assign rsp_saturation = stage_data[rgbhsl_pkg::NUM_CELLS].sat.quo;
   assign rsp_lightness  = stage_data[rgbhsl_pkg::NUM_CELLS].lightness;

endmodule

`default_nettype wire

// ===== rtl/rgbhsl_front.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_front: setup stage of the RGB to HSL converter
// Finds the extremes, works out lightness and loads both divider lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsl_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          up_valid,
   input  wire logic [7:0]                    red,
   input  wire logic [7:0]                    green,
   input  wire logic [7:0]                    blue,
   input  wire logic                          down_en,
   output logic                               valid,
   output rgbhsl_pkg::pixel_work_type         data,
   output logic                               en
);

   logic                       valid_ff, valid_in;
   rgbhsl_pkg::pixel_work_type data_ff, data_in;

   logic [7:0]         mx, mn, d;
   logic [8:0]         sum;
   logic [20:0]        light_prod;
   logic [7:0]         sat_den;
   logic [15:0]        sat_num;
   logic signed [11:0] r_s, g_s, b_s, d_s, sector, wrapped;
   logic [10:0]        hue_val;
   logic [15:0]        hue_num;
   logic               grey;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx)  mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn)  mn = blue;

      sum  = {1'b0, mx} + {1'b0, mn};
      d    = mx - mn;
      grey = (d == 8'd0);

      light_prod = {12'd0, sum} * {9'd0, rgbhsl_pkg::LIGHT_RECIP};

      // The spread never exceeds the denominator, so the quotient fits 8 bits.
      sat_den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
      sat_num = {d, 8'd0} - {4'd0, d, 4'd0};

      r_s = $signed({4'd0, red});
      g_s = $signed({4'd0, green});
      b_s = $signed({4'd0, blue});
      d_s = $signed({4'd0, d});
      if (red == mx) begin
         sector = g_s - b_s;
      end else if (green == mx) begin
         sector = (d_s <<< 1) + b_s - r_s;
      end else begin
         sector = (d_s <<< 2) + r_s - g_s;
      end
      wrapped = (sector < 0) ? sector + (d_s <<< 2) + (d_s <<< 1) : sector;
      hue_val = wrapped[10:0];
      hue_num = {hue_val, 5'd0} + {2'd0, hue_val, 3'd0};

      data_in.lightness      = light_prod[rgbhsl_pkg::LIGHT_SHIFT +: 8];
      data_in.hue.rem        = hue_num[15:8];
      data_in.hue.num_lo     = hue_num[7:0];
      data_in.hue.quo        = '0;
      data_in.hue.divisor    = grey ? 8'd1 : d;
      data_in.sat.rem        = sat_num[15:8];
      data_in.sat.num_lo     = sat_num[7:0];
      data_in.sat.quo        = '0;
      data_in.sat.divisor    = grey ? 8'd1 : sat_den;
   end

   assign en       = !valid_ff || down_en;
   assign valid_in = en ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/rgbhsl_cell.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_cell: one cell of the divider row
// Resolves one quotient bit of the hue and of the saturation division.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsl_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          up_valid,
   input  rgbhsl_pkg::pixel_work_type         up_data,
   input  wire logic                          down_en,
   output logic                               valid,
   output rgbhsl_pkg::pixel_work_type         data,
   output logic                               en
);

   function automatic rgbhsl_pkg::div_lane_type div_step(
      input rgbhsl_pkg::div_lane_type lane
   );
      rgbhsl_pkg::div_lane_type res;
      logic [8:0] trial;
      logic [8:0] diff;
      logic       ge;
      trial      = {lane.rem, lane.num_lo[7]};
      diff       = trial - {1'b0, lane.divisor};
      ge         = (trial >= {1'b0, lane.divisor});
      res        = lane;
      res.rem    = ge ? diff[7:0] : trial[7:0];
      res.num_lo = {lane.num_lo[6:0], 1'b0};
      res.quo    = {lane.quo[6:0], ge};
      return res;
   endfunction

   logic                       valid_ff, valid_in;
   rgbhsl_pkg::pixel_work_type data_ff, data_in;

   always_comb begin
      data_in     = up_data;
      data_in.hue = div_step(up_data.hue);
      data_in.sat = div_step(up_data.sat);
   end

   assign en       = !valid_ff || down_en;
   assign valid_in = en ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsl_240_checker.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_240_props: port-level checks for the RGB to HSL converter
// Watches the ports over time and is bound to every instance of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_240_props (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [7:0] req_red,
   input wire logic [7:0] req_green,
   input wire logic [7:0] req_blue,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_hue,
   input wire logic [7:0] rsp_saturation,
   input wire logic [7:0] rsp_lightness
);

   logic req_seen;
   assign req_seen = req_valid && (req_red == req_red) && (req_green == req_green)
                     && (req_blue == req_blue);

   // Reset empties the row, so no response word follows it.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response word shown just after reset");

   // Every response field lies on the 0 to 240 scale, hue below a full turn.
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue < 8'd240) && (rsp_saturation <= 8'd240)
                    && (rsp_lightness <= 8'd240))
      else $error("response field out of range");

   // The request side is held back only when a response word is stuck.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled while the response side is free");

   // A stalled response word holds.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_hue)
         && $stable(rsp_saturation) && $stable(rsp_lightness))
      else $error("stalled response word changed");

   // A request offered to an empty output is taken at once.
   a_take_offer : assert property (@(posedge clock) disable iff (reset)
      (req_seen && !rsp_valid) |-> !req_stall)
      else $error("request refused with an empty output stage");

endmodule

bind rgb_to_hsl_240 rgb_to_hsl_240_props u_checker (.*);

`default_nettype wire
